// ----- rtl/i2d_pkg.sv -----
// ----------------------------------------------------------------------------
// i2d_pkg: shared types and constants for the decimal ASCII printer
// Controller states, command and status bundles, character codes.
// ----------------------------------------------------------------------------
package i2d_pkg;

  localparam int ValueWidth = 64;
  localparam int NumDigits  = 20;
  localparam int DigitIdxW  = 5;
  localparam int StepCntW   = 6;
  localparam int GroupSize  = 3;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharComma = 8'h2C;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_COUNT,
    ST_SIGN,
    ST_DIGIT,
    ST_COMMA
  } state_t;

  typedef enum logic [1:0] {
    SEL_DIGIT,
    SEL_MINUS,
    SEL_COMMA
  } char_sel_t;

  typedef struct packed {
    logic      load;   // capture a new request
    logic      step;   // one shift-and-adjust step
    logic      count;  // find the leading digit
    logic      dec;    // move to the next lower digit
    char_sel_t sel;    // which character is shown
  } cmd_t;

  typedef struct packed {
    logic conv_done;   // last conversion step is under way
    logic k_zero;      // current digit is the units digit
    logic comma_due;   // a comma follows the current digit
    logic negative;    // a minus sign leads the text
  } status_t;

endpackage

// ----- rtl/i2d_ctrl.sv -----
// ----------------------------------------------------------------------------
// i2d_ctrl: sequencer for the decimal ASCII printer
// Steps through conversion, leading digit search and character output.
// ----------------------------------------------------------------------------
module i2d_ctrl
  import i2d_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output logic    out_last,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CONVERT;
      end
      ST_CONVERT: begin
        if (status.conv_done) state_next = ST_COUNT;
      end
      ST_COUNT: begin
        state_next = status.negative ? ST_SIGN : ST_DIGIT;
      end
      ST_SIGN: begin
        if (out_ready) state_next = ST_DIGIT;
      end
      ST_DIGIT: begin
        if (out_ready) begin
          priority if (status.k_zero) state_next = ST_IDLE;
          else if (status.comma_due)  state_next = ST_COMMA;
          else                        state_next = ST_DIGIT;
        end
      end
      ST_COMMA: begin
        if (out_ready) state_next = ST_DIGIT;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.sel   = SEL_DIGIT;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    out_last  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_CONVERT: cmd.step = 1'b1;
      ST_COUNT:   cmd.count = 1'b1;
      ST_SIGN: begin
        out_valid = 1'b1;
        cmd.sel   = SEL_MINUS;
      end
      ST_DIGIT: begin
        out_valid = 1'b1;
        out_last  = status.k_zero;
        cmd.dec   = out_ready && !status.k_zero;
      end
      ST_COMMA: begin
        out_valid = 1'b1;
        cmd.sel   = SEL_COMMA;
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/i2d_datapath.sv -----
// ----------------------------------------------------------------------------
// i2d_datapath: binary to BCD datapath of the decimal ASCII printer
// Shift-and-add-3 converter, leading digit search and character select.
// ----------------------------------------------------------------------------
module i2d_datapath
  import i2d_pkg::*;
(
  input  logic                  clk,
  input  logic [ValueWidth-1:0] value,
  input  logic [1:0]            opcode,
  input  cmd_t                  cmd,
  output status_t               status,
  output logic [7:0]            ascii_char
);

  logic [ValueWidth-1:0] bin;
  logic [3:0]            digits [NumDigits];
  logic [StepCntW-1:0]   cnt;
  logic [DigitIdxW-1:0]  k;
  logic [1:0]            mod3;
  logic                  negative;
  logic                  commas;

  logic [ValueWidth-1:0] magnitude;
  logic [3:0]            adj [NumDigits];
  logic [DigitIdxW-1:0]  lead_idx;
  logic [1:0]            lead_mod3;

  assign magnitude = (opcode[0] && value[ValueWidth-1]) ? (~value + ValueWidth'(1)) : value;

  // Add 3 to every digit of 5 or more ahead of the shift.
  always_comb begin
    for (int d = 0; d < NumDigits; d++) begin
      adj[d] = (digits[d] >= 4'd5) ? (digits[d] + 4'd3) : digits[d];
    end
  end

  // Highest nonzero digit; the units digit when the value is zero.
  always_comb begin
    lead_idx  = '0;
    lead_mod3 = '0;
    for (int i = 1; i < NumDigits; i++) begin
      if (digits[i] != 4'd0) begin
        lead_idx  = DigitIdxW'(i);
        lead_mod3 = 2'(i % GroupSize);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin      <= magnitude;
      cnt      <= '0;
      negative <= opcode[0] && value[ValueWidth-1];
      commas   <= opcode[1];
      for (int d = 0; d < NumDigits; d++) digits[d] <= 4'd0;
    end
    if (cmd.step) begin
      bin       <= {bin[ValueWidth-2:0], 1'b0};
      cnt       <= cnt + StepCntW'(1);
      digits[0] <= {adj[0][2:0], bin[ValueWidth-1]};
      for (int d = 1; d < NumDigits; d++) begin
        digits[d] <= {adj[d][2:0], adj[d-1][3]};
      end
    end
    if (cmd.count) begin
      k    <= lead_idx;
      mod3 <= lead_mod3;
    end
    if (cmd.dec) begin
      k    <= k - DigitIdxW'(1);
      mod3 <= (mod3 == 2'd0) ? 2'd2 : (mod3 - 2'd1);
    end
  end

  assign status.conv_done = (cnt == StepCntW'(ValueWidth - 1));
  assign status.k_zero    = (k == '0);
  assign status.comma_due = commas && (mod3 == 2'd0) && (k != '0);
  assign status.negative  = negative;

  always_comb begin
    unique case (cmd.sel)
      SEL_MINUS: ascii_char = CharMinus;
      SEL_COMMA: ascii_char = CharComma;
      default:   ascii_char = CharZero | {4'h0, digits[k]};
    endcase
  end

endmodule

// ----- rtl/int64_to_decimal_ascii.sv -----
// ----------------------------------------------------------------------------
// int64_to_decimal_ascii: 64-bit integer to decimal ASCII text
// Prints one value per request as a stream of characters, most significant
// first, with optional minus sign and thousands commas.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload                                   Ends with
//  s_axis    in         tdata[63:0] value, tdata[65:64] opcode    -
//  m_axis    out        tdata[7:0] ascii_char                     tlast = last_char
//
// A request is taken while the block is idle and then converted by a
// shift-and-add-3 loop, one step per value bit, followed by a step that
// finds the leading digit. The characters follow one per cycle while
// m_axis_tready is high; one request yields 1 to 26 characters.
// The loop length is set by the 64-bit binary to BCD converter.
// s_axis_tready is high only while the block is idle. A stall on m_axis
// holds the current character stable. Reset (rst, synchronous) returns the
// sequencer to idle and drops any request in progress.
//
// Opcode bit 0 reads the value as two's complement; the most negative value
// prints with its full magnitude. Opcode bit 1 places a comma between groups
// of three digits counted from the right, never straight after the sign.
// Zero prints as a single "0" in every mode.
module int64_to_decimal_ascii
  import i2d_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // [63:0] value, [65:64] opcode, rest zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] ascii_char
  output logic        m_axis_tlast
);

  cmd_t    cmd;
  status_t status;

  // Upper padding bits of the request carry no information.
  logic unused_pad;
  assign unused_pad = ^s_axis_tdata[71:66];

  i2d_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_last  (m_axis_tlast),
    .status    (status),
    .cmd       (cmd)
  );

  i2d_datapath u_datapath (
    .clk        (clk),
    .value      (s_axis_tdata[63:0]),
    .opcode     (s_axis_tdata[65:64]),
    .cmd        (cmd),
    .status     (status),
    .ascii_char (m_axis_tdata)
  );

endmodule

// ----- rtl/i2d_checker.sv -----
// ----------------------------------------------------------------------------
// i2d_checker: port-level checks for the decimal ASCII printer
// Watches request intake and character output over time.
// ----------------------------------------------------------------------------
module i2d_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  // A stalled character holds.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("stalled character changed");

  // Only one request is in flight at a time.
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready && !m_axis_tvalid)
    else $error("request overlap or early output");

  // No request is taken while text is going out.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("intake open during output");

  // The characters of one number leave without gaps.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("gap inside a number");

endmodule

bind int64_to_decimal_ascii i2d_checker u_i2d_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
